// ===== rtl/core/pbcs_pkg.sv =====
// shared constants and types for the paletted bilinear colour sampler
`timescale 1ns / 1ps

package pbcs_pkg;

    localparam int MAP_DIM       = 1024;
    localparam int CELL_SIZE     = 1024;
    localparam int PALETTE_DEPTH = 256;

    localparam int COORD_W  = 20;
    localparam int FRAC_W   = 10;
    localparam int FRAC_ONE = 1 << FRAC_W;
    localparam int IDX_W    = $clog2(MAP_DIM);
    localparam int PAL_AW   = $clog2(PALETTE_DEPTH);

    // cell size and map side are powers of two, so splits are shifts and masks
    localparam int CELL_W   = $clog2(CELL_SIZE);

    // map is split into four banks by column and row parity
    localparam int BANK_DIM   = MAP_DIM / 2;
    localparam int BANK_AW    = 2 * (IDX_W - 1);
    localparam int BANK_DEPTH = BANK_DIM * BANK_DIM;
    localparam int MAP_SIZE   = MAP_DIM * MAP_DIM;

    typedef logic [1:0]               func_t;
    typedef logic [COORD_W-1:0]       coord_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [FRAC_W-1:0]        frac_t;
    typedef logic [FRAC_W:0]          frac1_t;
    typedef logic [7:0]               texel_t;
    typedef logic [7:0]               chan_t;
    typedef logic [23:0]              rgb_t;
    typedef logic [BANK_AW-1:0]       bank_addr_t;
    typedef logic [1:0]               bank_sel_t;
    typedef logic [PAL_AW-1:0]        pal_addr_t;
    typedef logic [17:0]              zsum_t;
    typedef logic [27:0]              xsum_t;
    typedef logic [15:0]              out_t;

    localparam func_t FUNC_SAMPLE = 2'd0;
    localparam func_t FUNC_MAP_WR = 2'd1;
    localparam func_t FUNC_PAL_WR = 2'd2;

    localparam out_t OUT_MAX = 16'd65280;

endpackage

// ===== rtl/core/palette_bilinear_colour_sampler_core.sv =====
// paletted bilinear colour sampler: banked index map, replicated palette, two lerp stages
`timescale 1ns / 1ps
//
//  channel   handshake      fields                                            dir
//  -------   ------------   -----------------------------------------------   ---
//  command   start / busy   func, coord_x, coord_z, texel_address,            in
//                           texel_value, entry_index, entry_red/green/blue
//  result    done           red_out, green_out, blue_out                      out
//
//  one command beat per cycle; busy stays low, every beat is taken
//  a sample passes through these steps in order: coordinate split,
//  map bank read, palette read, lerp along z, lerp along x into the output register
//  four map banks (column/row parity) and four palette copies give the four
//  neighbours in the same cycle; writes pass through the same stages in order
//  reset clears only the stage valid flags; map and palette hold garbage until written

module palette_bilinear_colour_sampler_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  pbcs_pkg::func_t        func,
    input  pbcs_pkg::coord_t       coord_x,
    input  pbcs_pkg::coord_t       coord_z,
    input  pbcs_pkg::coord_t       texel_address,
    input  pbcs_pkg::texel_t       texel_value,
    input  pbcs_pkg::texel_t       entry_index,
    input  pbcs_pkg::chan_t        entry_red,
    input  pbcs_pkg::chan_t        entry_green,
    input  pbcs_pkg::chan_t        entry_blue,
    output logic                   done,
    output pbcs_pkg::out_t         red_out,
    output pbcs_pkg::out_t         green_out,
    output pbcs_pkg::out_t         blue_out
);

    // returns {index, fraction}; index past the map saturates with zero fraction
    function automatic logic [pbcs_pkg::IDX_W+pbcs_pkg::FRAC_W-1:0] split_coord(
        input pbcs_pkg::coord_t c
    );
        pbcs_pkg::coord_t i;
        pbcs_pkg::coord_t rem;
        logic [31:0]      scaled;
        i      = c >> pbcs_pkg::CELL_W;
        rem    = c & pbcs_pkg::coord_t'(pbcs_pkg::CELL_SIZE - 1);
        scaled = 32'(rem) << pbcs_pkg::FRAC_W;
        if (i > pbcs_pkg::coord_t'(pbcs_pkg::MAP_DIM - 1))
            return {pbcs_pkg::idx_t'(pbcs_pkg::MAP_DIM - 1), pbcs_pkg::frac_t'(0)};
        return {i[pbcs_pkg::IDX_W-1:0], scaled[pbcs_pkg::CELL_W +: pbcs_pkg::FRAC_W]};
    endfunction

    function automatic pbcs_pkg::idx_t next_clamped(input pbcs_pkg::idx_t i);
        if (i == pbcs_pkg::idx_t'(pbcs_pkg::MAP_DIM - 1))
            return i;
        return i + pbcs_pkg::idx_t'(1);
    endfunction

    logic accept;

    // command decode
    pbcs_pkg::idx_t       in_ix, in_iz, in_wrow, in_wcol;
    pbcs_pkg::frac_t      in_fx, in_fz;
    logic                 in_map_ok, in_pal_ok;

    // stage a: split coordinates, write requests
    logic                 a_smp_reg, a_smp_next;
    logic                 a_map_we_reg, a_map_we_next;
    logic                 a_pal_we_reg, a_pal_we_next;
    pbcs_pkg::idx_t       a_ix_reg, a_iz_reg;
    pbcs_pkg::frac_t      a_fx_reg, a_fz_reg;
    pbcs_pkg::bank_addr_t a_waddr_reg;
    pbcs_pkg::bank_sel_t  a_wbank_reg;
    pbcs_pkg::texel_t     a_wdata_reg;
    pbcs_pkg::pal_addr_t  a_pal_idx_reg;
    pbcs_pkg::rgb_t       a_pal_rgb_reg;

    pbcs_pkg::idx_t       a_ix2, a_iz2;
    pbcs_pkg::bank_addr_t bank_raddr [4];

    // stage b: map bank read data
    logic                 b_smp_reg;
    logic                 b_pal_we_reg;
    pbcs_pkg::pal_addr_t  b_pal_idx_reg;
    pbcs_pkg::rgb_t       b_pal_rgb_reg;
    pbcs_pkg::frac_t      b_fx_reg, b_fz_reg;
    logic                 b_xs0_reg, b_xs1_reg, b_zs0_reg, b_zs1_reg;
    pbcs_pkg::texel_t     bank_q [4];

    pbcs_pkg::texel_t     b_tex [4];
    pbcs_pkg::pal_addr_t  pal_raddr [4];
    logic                 b_black [4];

    // stage c: palette read data
    logic                 c_smp_reg;
    pbcs_pkg::frac_t      c_fx_reg, c_fz_reg;
    logic                 c_black_reg [4];
    pbcs_pkg::rgb_t       pal_q [4];

    pbcs_pkg::rgb_t       c_rgb [4];
    pbcs_pkg::frac1_t     c_fz1;
    pbcs_pkg::zsum_t      c_left [3];
    pbcs_pkg::zsum_t      c_right [3];

    // stage d: lerp along z done
    logic                 d_smp_reg;
    pbcs_pkg::frac_t      d_fx_reg;
    pbcs_pkg::zsum_t      d_left_reg [3];
    pbcs_pkg::zsum_t      d_right_reg [3];

    pbcs_pkg::frac1_t     d_fx1;
    pbcs_pkg::xsum_t      d_t [3];

    // result
    logic                 done_reg;
    pbcs_pkg::out_t       out_reg [3];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        {in_ix, in_fx} = split_coord(coord_x);
        {in_iz, in_fz} = split_coord(coord_z);
        in_wrow   = pbcs_pkg::idx_t'(texel_address >> pbcs_pkg::IDX_W);
        in_wcol   = texel_address[pbcs_pkg::IDX_W-1:0];
        in_map_ok = 32'(texel_address) < 32'(pbcs_pkg::MAP_SIZE);
        in_pal_ok = 32'(entry_index) < 32'(pbcs_pkg::PALETTE_DEPTH);
        a_smp_next    = accept && (func == pbcs_pkg::FUNC_SAMPLE);
        a_map_we_next = accept && (func == pbcs_pkg::FUNC_MAP_WR) && in_map_ok;
        a_pal_we_next = accept && (func == pbcs_pkg::FUNC_PAL_WR) && in_pal_ok;
    end

    // bank b holds texels with column parity b[0] and row parity b[1]
    always_comb
    begin
        pbcs_pkg::idx_t col;
        pbcs_pkg::idx_t row;
        a_ix2 = next_clamped(a_ix_reg);
        a_iz2 = next_clamped(a_iz_reg);
        for (int b = 0; b < 4; b++)
        begin
            col = (a_ix_reg[0] == b[0]) ? a_ix_reg : a_ix2;
            row = (a_iz_reg[0] == b[1]) ? a_iz_reg : a_iz2;
            bank_raddr[b] = {row[pbcs_pkg::IDX_W-1:1], col[pbcs_pkg::IDX_W-1:1]};
        end
    end

    always_comb
    begin
        b_tex[0] = bank_q[{b_zs0_reg, b_xs0_reg}];
        b_tex[1] = bank_q[{b_zs0_reg, b_xs1_reg}];
        b_tex[2] = bank_q[{b_zs1_reg, b_xs0_reg}];
        b_tex[3] = bank_q[{b_zs1_reg, b_xs1_reg}];
        for (int k = 0; k < 4; k++)
        begin
            pal_raddr[k] = pbcs_pkg::pal_addr_t'(b_tex[k]);
            b_black[k]   = 32'(b_tex[k]) >= 32'(pbcs_pkg::PALETTE_DEPTH);
        end
    end

    // neighbour order: top left, top right, bottom left, bottom right
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            c_rgb[k] = c_black_reg[k] ? pbcs_pkg::rgb_t'(0) : pal_q[k];
        c_fz1 = pbcs_pkg::frac1_t'(pbcs_pkg::FRAC_ONE) - pbcs_pkg::frac1_t'(c_fz_reg);
        for (int ch = 0; ch < 3; ch++)
        begin
            c_left[ch]  = pbcs_pkg::zsum_t'(c_rgb[0][23-8*ch -: 8]) * pbcs_pkg::zsum_t'(c_fz1)
                        + pbcs_pkg::zsum_t'(c_rgb[2][23-8*ch -: 8]) * pbcs_pkg::zsum_t'(c_fz_reg);
            c_right[ch] = pbcs_pkg::zsum_t'(c_rgb[1][23-8*ch -: 8]) * pbcs_pkg::zsum_t'(c_fz1)
                        + pbcs_pkg::zsum_t'(c_rgb[3][23-8*ch -: 8]) * pbcs_pkg::zsum_t'(c_fz_reg);
        end
    end

    always_comb
    begin
        d_fx1 = pbcs_pkg::frac1_t'(pbcs_pkg::FRAC_ONE) - pbcs_pkg::frac1_t'(d_fx_reg);
        for (int ch = 0; ch < 3; ch++)
            d_t[ch] = pbcs_pkg::xsum_t'(d_left_reg[ch]) * pbcs_pkg::xsum_t'(d_fx1)
                    + pbcs_pkg::xsum_t'(d_right_reg[ch]) * pbcs_pkg::xsum_t'(d_fx_reg);
    end

    for (genvar gb = 0; gb < 4; gb++)
    begin : g_bank
        pbcs_pkg::texel_t map_mem [pbcs_pkg::BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (a_map_we_reg && (a_wbank_reg == pbcs_pkg::bank_sel_t'(gb)))
                map_mem[a_waddr_reg] <= a_wdata_reg;
            bank_q[gb] <= map_mem[bank_raddr[gb]];
        end
    end

    // one palette copy per neighbour, all written together
    for (genvar gp = 0; gp < 4; gp++)
    begin : g_pal
        pbcs_pkg::rgb_t pal_mem [pbcs_pkg::PALETTE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (b_pal_we_reg)
                pal_mem[b_pal_idx_reg] <= b_pal_rgb_reg;
            pal_q[gp] <= pal_mem[pal_raddr[gp]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_smp_reg    <= 1'b0;
            a_map_we_reg <= 1'b0;
            a_pal_we_reg <= 1'b0;
            b_smp_reg    <= 1'b0;
            b_pal_we_reg <= 1'b0;
            c_smp_reg    <= 1'b0;
            d_smp_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            a_smp_reg    <= a_smp_next;
            a_map_we_reg <= a_map_we_next;
            a_pal_we_reg <= a_pal_we_next;
            b_smp_reg    <= a_smp_reg;
            b_pal_we_reg <= a_pal_we_reg;
            c_smp_reg    <= b_smp_reg;
            d_smp_reg    <= c_smp_reg;
            done_reg     <= d_smp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ix_reg      <= in_ix;
        a_iz_reg      <= in_iz;
        a_fx_reg      <= in_fx;
        a_fz_reg      <= in_fz;
        a_waddr_reg   <= {in_wrow[pbcs_pkg::IDX_W-1:1], in_wcol[pbcs_pkg::IDX_W-1:1]};
        a_wbank_reg   <= {in_wrow[0], in_wcol[0]};
        a_wdata_reg   <= texel_value;
        a_pal_idx_reg <= pbcs_pkg::pal_addr_t'(entry_index);
        a_pal_rgb_reg <= {entry_red, entry_green, entry_blue};

        b_pal_idx_reg <= a_pal_idx_reg;
        b_pal_rgb_reg <= a_pal_rgb_reg;
        b_fx_reg      <= a_fx_reg;
        b_fz_reg      <= a_fz_reg;
        b_xs0_reg     <= a_ix_reg[0];
        b_xs1_reg     <= a_ix2[0];
        b_zs0_reg     <= a_iz_reg[0];
        b_zs1_reg     <= a_iz2[0];

        c_fx_reg      <= b_fx_reg;
        c_fz_reg      <= b_fz_reg;
        for (int k = 0; k < 4; k++)
            c_black_reg[k] <= b_black[k];

        d_fx_reg      <= c_fx_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            d_left_reg[ch]  <= c_left[ch];
            d_right_reg[ch] <= c_right[ch];
            out_reg[ch]     <= d_t[ch][27:12];
        end
    end

    assign done      = done_reg;
    assign red_out   = out_reg[0];
    assign green_out = out_reg[1];
    assign blue_out  = out_reg[2];

endmodule

// ===== rtl/core/pbcs_checker.sv =====
// port-level checks for the colour sampler, bound to the top level
`timescale 1ns / 1ps

module pbcs_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input pbcs_pkg::func_t        func,
    input logic                   done,
    input pbcs_pkg::out_t         red_out,
    input pbcs_pkg::out_t         green_out,
    input pbcs_pkg::out_t         blue_out
);

    // the sampler takes a beat every cycle
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // every accepted sample returns a result
    a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (func == pbcs_pkg::FUNC_SAMPLE) |-> ##5 done)
        else $error("sample result missing");

    // no result without an earlier accepted sample
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5) && !$past(busy, 5)
                 && ($past(func, 5) == pbcs_pkg::FUNC_SAMPLE))
        else $error("result without sample");

    // interpolated channels never exceed full scale
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red_out <= pbcs_pkg::OUT_MAX) && (green_out <= pbcs_pkg::OUT_MAX)
                 && (blue_out <= pbcs_pkg::OUT_MAX))
        else $error("channel out of range");

endmodule

bind palette_bilinear_colour_sampler_core pbcs_checker u_pbcs_checker (.*);
